// ===== src/cle_pkg.sv =====
// Shared types, byte codes and echo sequence table for the console line editor.
// No dependencies; compiled first.
`default_nettype none

package cle_pkg;

    // Width of the line capacity register.
    localparam int unsigned CapW = 6;

    // Capacity after reset.
    localparam logic [CapW-1:0] CapReset = 6'd32;

    // Byte codes that the editor recognizes or emits.
    localparam logic [7:0] ChDel    = 8'h7F;
    localparam logic [7:0] ChBs     = 8'h08;
    localparam logic [7:0] ChEtx    = 8'h03;
    localparam logic [7:0] ChCr     = 8'h0D;
    localparam logic [7:0] ChLf     = 8'h0A;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChCaret  = 8'h5E;
    localparam logic [7:0] ChUpperC = 8'h43;

    // Kind of echo sequence that an input byte causes.
    typedef enum logic [1:0] {
        ECHO_CHAR,
        ECHO_ERASE,
        ECHO_INTR,
        ECHO_NEWLINE
    } echo_kind_t;

    // Index of the final byte of each echo sequence.
    function automatic logic [1:0] cle_echo_last(input echo_kind_t kind);
        logic [1:0] res;
        unique case (kind)
            ECHO_CHAR:    res = 2'd0;
            ECHO_ERASE:   res = 2'd2;
            ECHO_INTR:    res = 2'd3;
            ECHO_NEWLINE: res = 2'd1;
            default:      res = 2'd0;
        endcase
        return res;
    endfunction

    // Byte at position idx of an echo sequence; ch is the received byte.
    function automatic logic [7:0] cle_echo_byte(input echo_kind_t kind,
                                                 input logic [1:0] idx,
                                                 input logic [7:0] ch);
        logic [7:0] res;
        res = ch;
        unique case (kind)
            ECHO_CHAR:    res = ch;
            ECHO_ERASE:   res = (idx == 2'd1) ? ChSpace : ChBs;
            ECHO_INTR:
            begin
                case (idx)
                    2'd0:    res = ChCaret;
                    2'd1:    res = ChUpperC;
                    2'd2:    res = ChCr;
                    default: res = ChLf;
                endcase
            end
            ECHO_NEWLINE: res = (idx == 2'd0) ? ChCr : ChLf;
            default:      res = ch;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/cle_if.sv =====
// Valid/ready channel interfaces of the console line editor: received bytes,
// emitted bytes and the capacity register write. Depends on cle_pkg.
`default_nettype none

interface cle_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       to_line;
    logic       last;

    modport source (output valid, output out_byte, output to_line, output last, input ready);
    modport sink (input valid, input out_byte, input to_line, input last, output ready);
endinterface

interface cle_cfg_if;
    import cle_pkg::*;
    logic            valid;
    logic            ready;
    logic [CapW-1:0] line_capacity;

    modport source (output valid, output line_capacity, input ready);
    modport sink (input valid, input line_capacity, output ready);
endinterface

`default_nettype wire

// ===== src/console_line_editor.sv =====
// Input bytes are taken only in the idle state; the first echo byte is offered from
// the output register after the state register has entered the echo state. A new
// input byte is accepted only once its echo and any line delivery are done (an erase
// on an empty line echoes nothing); a line is read byte by byte through the single store read port.
// Reset clears the fill count and output valid and sets the capacity to 32;
// the line store is not cleared, only entries below the fill count are read.
`default_nettype none

module console_line_editor #(
    parameter int unsigned LINE_MAX = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    cle_rx_if.sink      rx,
    cle_tx_if.source    tx,
    cle_cfg_if.sink     cfg
);
    import cle_pkg::*;

    localparam int unsigned FillW = $clog2(LINE_MAX + 1);
    localparam int unsigned AddrW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int unsigned CmpW  = CapW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_DRAIN
    } state_t;

    // Control and payload registers.
    state_t            state_reg, state_next;
    logic [FillW-1:0]  fill_reg, fill_next;
    logic [CapW-1:0]   cap_reg;
    echo_kind_t        kind_reg, kind_next;
    logic [7:0]        char_reg, char_next;
    logic [1:0]        echo_idx_reg, echo_idx_next;
    logic              drain_reg, drain_next;
    logic [FillW-1:0]  drain_len_reg, drain_len_next;
    logic [FillW-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              to_line_reg, to_line_next;
    logic              last_reg, last_next;

    // Line store and its port signals.
    logic [7:0]        line_mem [LINE_MAX];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [7:0]        wr_data;
    logic              rd_en;

    logic              adv;
    logic              in_xfer;
    logic [CapW-1:0]   eff_cap;
    logic [FillW-1:0]  fill_inc;
    logic              can_store;
    logic              echo_done;
    logic              rd_more;

    assign rx.ready  = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign in_xfer   = rx.valid && (state_reg == ST_IDLE);

    assign tx.valid    = out_valid_reg;
    assign tx.out_byte = out_byte_reg;
    assign tx.to_line  = to_line_reg;
    assign tx.last     = last_reg;

    // The output register can take a new byte when empty or being drained.
    assign adv = !out_valid_reg || tx.ready;

    // Capacity clamped to the range 1 .. LINE_MAX.
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = CapW'(1);
        else if (CmpW'(cap_reg) > CmpW'(LINE_MAX))
            eff_cap = CapW'(LINE_MAX);
        else
            eff_cap = cap_reg;
    end

    assign can_store = (fill_reg < FillW'(LINE_MAX));
    assign fill_inc  = can_store ? fill_reg + FillW'(1) : fill_reg;
    assign echo_done = (echo_idx_reg == cle_echo_last(kind_reg));
    assign rd_more   = (rd_idx_reg < drain_len_reg);

    // Next-state logic: decode on transfer, then echo, then drain the line when one is delivered.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        kind_next      = kind_reg;
        char_next      = char_reg;
        echo_idx_next  = echo_idx_reg;
        drain_next     = drain_reg;
        drain_len_next = drain_len_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        out_byte_next  = out_byte_reg;
        to_line_next   = to_line_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_data        = rx.rx_byte;
        rd_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    char_next     = rx.rx_byte;
                    echo_idx_next = 2'd0;
                    drain_next    = 1'b0;
                    if (rx.rx_byte == ChDel || rx.rx_byte == ChBs)
                    begin
                        // Erase on an empty line produces nothing.
                        if (fill_reg != '0)
                        begin
                            fill_next  = fill_reg - FillW'(1);
                            kind_next  = ECHO_ERASE;
                            state_next = ST_ECHO;
                        end
                    end
                    else if (rx.rx_byte == ChEtx)
                    begin
                        fill_next  = '0;
                        kind_next  = ECHO_INTR;
                        state_next = ST_ECHO;
                    end
                    else if (rx.rx_byte == ChCr || rx.rx_byte == ChLf)
                    begin
                        wr_en          = can_store;
                        wr_data        = ChLf;
                        kind_next      = ECHO_NEWLINE;
                        drain_next     = 1'b1;
                        drain_len_next = fill_inc;
                        fill_next      = '0;
                        state_next     = ST_ECHO;
                    end
                    else
                    begin
                        wr_en      = can_store;
                        kind_next  = ECHO_CHAR;
                        state_next = ST_ECHO;
                        if (CmpW'(fill_inc) >= CmpW'(eff_cap))
                        begin
                            drain_next     = 1'b1;
                            drain_len_next = fill_inc;
                            fill_next      = '0;
                        end
                        else
                        begin
                            fill_next = fill_inc;
                        end
                    end
                end
            end
            ST_ECHO:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cle_echo_byte(kind_reg, echo_idx_reg, char_reg);
                    to_line_next   = 1'b0;
                    last_next      = echo_done && !drain_reg;
                    if (echo_done)
                    begin
                        state_next  = drain_reg ? ST_DRAIN : ST_IDLE;
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                    end
                    else
                    begin
                        echo_idx_next = echo_idx_reg + 2'd1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // A read is issued when its data slot is free or being emptied.
                rd_en = rd_more && (!pend_reg || adv);
                if (pend_reg && adv)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    to_line_next   = 1'b1;
                    last_next      = !rd_more;
                    if (!rd_more)
                        state_next = ST_IDLE;
                end
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + FillW'(1);
                    pend_next   = 1'b1;
                end
                else if (pend_reg && adv)
                begin
                    pend_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Line store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[fill_reg[AddrW-1:0]] <= wr_data;
        if (rd_en)
            rd_data_reg <= line_mem[rd_idx_reg[AddrW-1:0]];
    end

    // State, counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cap_reg       <= CapReset;
            drain_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                cap_reg <= cfg.line_capacity;
        end
    end

    // Payload and sequencing registers without reset.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        char_reg      <= char_next;
        echo_idx_reg  <= echo_idx_next;
        drain_len_reg <= drain_len_next;
        rd_idx_reg    <= rd_idx_next;
        out_byte_reg  <= out_byte_next;
        to_line_reg   <= to_line_next;
        last_reg      <= last_next;
    end

`ifndef SYNTHESIS
    // The fill count always leaves room for one more stored byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FillW'(LINE_MAX))
    else $error("fill count reached the store depth");

    // The drain never reads past the line it is delivering.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (rd_idx_reg <= drain_len_reg))
    else $error("drain read index beyond line length");

    // Emitting the final line byte returns the editor to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DRAIN) && pend_reg && adv && !rd_more)
        |=> (state_reg == ST_IDLE) && out_valid_reg && last_reg && to_line_reg)
    else $error("line delivery did not close properly");
`endif

endmodule

`default_nettype wire
